[hdl/lcpc_pkg.sv]
// Shared widths and register indexes of the comet pixel colour block.
package lcpc_pkg;

  localparam int TICK_W     = 32;
  localparam int PIXEL_W    = 10;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_INDEX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIRTUAL_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_COLOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMET_SIZE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR    = 3'd7;

endpackage

[hdl/lcpc_in_if.sv]
// Input channel of the comet pixel colour block: tick and pixel index.
interface lcpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcpc_pkg::TICK_W-1:0]  tick;
  logic [lcpc_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output tick, output pixel, input ready);
  modport sink   (input valid, input tick, input pixel, output ready);
endinterface

[hdl/lcpc_out_if.sv]
// Result channel of the comet pixel colour block: written flag and colour.
interface lcpc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        written;
  logic [lcpc_pkg::COLOR_W-1:0] color;

  modport source (output valid, output written, output color, input ready);
  modport sink   (input valid, input written, input color, output ready);
endinterface

[hdl/led_comet_pixel_color.sv]
// Comet pixel colour renderer: one pixel of a comet frame per beat.
//
// The block takes one beat per clock when the result side does not stall and
// returns one result beat for each, in order. Its stages work the remainder
// of the 33-bit sum of tick and offset by the virtual length, four bits per
// stage over nine stages, followed by a small remainder for wrapped comets,
// the colour products and an 8-bit restoring division per channel. Every
// stage holds its own valid bit, so bubbles close up and a stall on the
// result side loses nothing.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and must
// only change while no beat is in flight.
module led_comet_pixel_color #(
  parameter int NUM_PIXELS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lcpc_in_if.sink                           in_bus,
  lcpc_out_if.source                        out_bus,
  input  logic                              cfg_we,
  input  logic [lcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CH_W      = lcpc_pkg::CH_W;
  localparam int DVD_W     = lcpc_pkg::TICK_W + 1;
  localparam int MOD_STEP  = 4;
  localparam int MOD_STAGES = (DVD_W + MOD_STEP - 1) / MOD_STEP;
  localparam int DVD_PAD   = MOD_STAGES * MOD_STEP;
  localparam int K_STEP    = 4;
  localparam int K_STAGES  = CH_W / K_STEP;
  localparam int Q_STEP    = 4;
  localparam int Q_STAGES  = CH_W / Q_STEP;
  localparam int ST_D      = 1 + MOD_STAGES;
  localparam int ST_K0     = ST_D + 1;
  localparam int ST_M      = ST_K0 + K_STAGES;
  localparam int ST_A      = ST_M + 1;
  localparam int ST_Q0     = ST_A + 1;
  localparam int NSTG      = ST_Q0 + Q_STAGES;
  localparam logic [16:0] NPIX = 17'(NUM_PIXELS);

  typedef struct packed {
    logic                                 written;
    logic                                 lit;
    logic [lcpc_pkg::PIXEL_W-1:0]         v;
    logic [DVD_PAD-1:0]                   dvd;
    logic [15:0]                          rem;
    logic [CH_W-1:0]                      kr;
    logic [CH_W-1:0]                      kd;
    logic [2:0][15:0]                     p0;
    logic [2:0][15:0]                     p1;
    logic [2:0][CH_W-1:0]                 qr;
    logic [2:0][CH_W-1:0]                 qd;
  } stage_t;

  // Configuration registers.
  logic [9:0]  start_r;
  logic [9:0]  end_r;
  logic [15:0] vlen_r;
  logic [15:0] offset_r;
  logic [23:0] tail_r;
  logic [23:0] head_r;
  logic [7:0]  size_r;
  logic        rev_r;

  logic [15:0] vlen_eff;
  logic [7:0]  span;

  stage_t              stg_r   [NSTG];
  stage_t              stg_nxt [NSTG];
  logic [NSTG-1:0]     vld_r;
  logic [NSTG:0]       rdy;

  logic                 out_valid_r;
  logic                 out_written_r;
  logic [23:0]          out_color_r;
  logic                 out_written_nxt;
  logic [23:0]          out_color_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      vlen_r   <= 16'd1;
      offset_r <= '0;
      tail_r   <= '0;
      head_r   <= '0;
      size_r   <= '0;
      rev_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcpc_pkg::REG_START_INDEX:    start_r  <= cfg_wdata[9:0];
        lcpc_pkg::REG_END_INDEX:      end_r    <= cfg_wdata[9:0];
        lcpc_pkg::REG_VIRTUAL_LENGTH: vlen_r   <= cfg_wdata[15:0];
        lcpc_pkg::REG_TICK_OFFSET:    offset_r <= cfg_wdata[15:0];
        lcpc_pkg::REG_TAIL_COLOR:     tail_r   <= cfg_wdata[23:0];
        lcpc_pkg::REG_HEAD_COLOR:     head_r   <= cfg_wdata[23:0];
        lcpc_pkg::REG_COMET_SIZE:     size_r   <= cfg_wdata[7:0];
        lcpc_pkg::REG_REVERSE_DIR:    rev_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A virtual length of zero behaves as one.
  assign vlen_eff = (vlen_r == 16'd0) ? 16'd1 : vlen_r;
  assign span     = size_r - 8'd1;

  // Each stage moves on when it is empty or the next one moves on.
  always_comb begin
    rdy[NSTG] = !out_valid_r || out_bus.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_bus.ready = rdy[0];

  always_comb begin
    stage_t      s;
    logic [32:0] sum;
    logic [16:0] rw;
    logic [16:0] dd;
    logic [8:0]  kw;
    logic [8:0]  qw;
    logic [7:0]  ii;
    logic [16:0] ps;

    // Entry stage: segment test, segment position and the tick sum.
    s = '0;
    rw = '0;
    dd = '0;
    kw = '0;
    qw = '0;
    ii = '0;
    ps = '0;
    sum = {1'b0, in_bus.tick} + {17'd0, offset_r};
    s.written = (in_bus.pixel >= start_r) && (in_bus.pixel <= end_r) &&
                ({7'd0, in_bus.pixel} < NPIX);
    s.v = rev_r ? (end_r - in_bus.pixel) : (in_bus.pixel - start_r);
    s.lit = s.written && ({6'd0, s.v} < vlen_eff) && (size_r != 8'd0);
    s.dvd = {{(DVD_PAD - DVD_W){1'b0}}, sum};
    s.rem = '0;
    stg_nxt[0] = s;

    for (int k = 1; k < NSTG; k++) begin
      s = stg_r[k-1];
      if (k < ST_D) begin
        // Head position: restoring remainder by the virtual length.
        for (int j = 0; j < MOD_STEP; j++) begin
          rw = {s.rem, s.dvd[DVD_PAD-1]};
          s.dvd = {s.dvd[DVD_PAD-2:0], 1'b0};
          if (rw >= {1'b0, vlen_eff}) begin
            rw = rw - {1'b0, vlen_eff};
          end
          s.rem = rw[15:0];
        end
      end else if (k == ST_D) begin
        dd = {1'b0, s.rem} + {1'b0, vlen_eff} - {7'd0, s.v};
        if (dd >= {1'b0, vlen_eff}) begin
          dd = dd - {1'b0, vlen_eff};
        end
        s.lit = s.lit && (dd[15:0] < {8'd0, size_r});
        s.kd  = span - dd[7:0];
        s.kr  = '0;
      end else if (k < ST_M) begin
        // Wrapped comets: (span - d) mod length gives the distance from the
        // largest comet index down to the one that lands here.
        for (int j = 0; j < K_STEP; j++) begin
          kw = {s.kr, s.kd[CH_W-1]};
          s.kd = {s.kd[CH_W-2:0], 1'b0};
          if ({7'd0, kw} >= vlen_eff) begin
            kw = kw - vlen_eff[8:0];
          end
          s.kr = kw[7:0];
        end
      end else if (k == ST_M) begin
        ii = span - s.kr;
        for (int c = 0; c < 3; c++) begin
          s.p0[c] = {8'd0, tail_r[8*c +: 8]} * {8'd0, s.kr};
          s.p1[c] = {8'd0, head_r[8*c +: 8]} * {8'd0, ii};
        end
      end else if (k == ST_A) begin
        // The quotient fits in eight bits, so the high byte of the
        // numerator is already a partial remainder below the span.
        for (int c = 0; c < 3; c++) begin
          ps = {1'b0, s.p0[c]} + {1'b0, s.p1[c]};
          s.qr[c] = ps[15:8];
          s.qd[c] = ps[7:0];
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          for (int j = 0; j < Q_STEP; j++) begin
            qw = {s.qr[c], s.qd[c][CH_W-1]};
            if (qw >= {1'b0, span}) begin
              qw = qw - {1'b0, span};
              s.qd[c] = {s.qd[c][CH_W-2:0], 1'b1};
            end else begin
              s.qd[c] = {s.qd[c][CH_W-2:0], 1'b0};
            end
            s.qr[c] = qw[7:0];
          end
        end
      end
      stg_nxt[k] = s;
    end
  end

  always_comb begin
    out_written_nxt = stg_r[NSTG-1].written;
    if (!stg_r[NSTG-1].lit) begin
      out_color_nxt = '0;
    end else if (span == 8'd0) begin
      out_color_nxt = tail_r;
    end else begin
      out_color_nxt = {stg_r[NSTG-1].qd[2], stg_r[NSTG-1].qd[1], stg_r[NSTG-1].qd[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_bus.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[NSTG]) begin
        out_valid_r <= vld_r[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (rdy[NSTG]) begin
      out_written_r <= out_written_nxt;
      out_color_r   <= out_color_nxt;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.written = out_written_r;
  assign out_bus.color   = out_color_r;

endmodule

[hdl/lcpc_chk.sv]
// Port checker for the comet pixel colour block and its bind.
module lcpc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_written,
  input logic [23:0] out_color
);

  // A pixel outside the segment always reports black.
  a_unwritten_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_written |-> out_color == 24'd0)
    else $error("unwritten pixel carries a colour");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  // With nothing waiting at the output the whole pipeline can advance.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(out_written))
    else $error("stalled result beat changed");

endmodule

bind led_comet_pixel_color lcpc_chk u_lcpc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_written (out_bus.written),
  .out_color   (out_bus.color)
);
